FILE: sv/cle_pkg.sv
`timescale 1ns / 1ps
package cle_pkg;

	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INS_TAIL = 2'd0,
		ACT_INS_HEAD = 2'd1,
		ACT_DELETE   = 2'd2,
		ACT_SEARCH   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    ins;
		logic    scan_init;
		logic    scan_step;
		logic    cap_pos;
		logic    shift_wr;
		logic    del_commit;
		logic    finish;
		status_t status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		action_t action;
		logic    full;
		logic    empty;
		logic    match;
		logic    last;
		logic    cmp_vld;
		logic    out_free;
	} dp_sts_t;

endpackage

FILE: sv/cle_in_if.sv
`timescale 1ns / 1ps
interface cle_in_if;
	logic                                valid;
	logic                                ready;
	logic [cle_pkg::ACTION_W-1:0]        action;
	logic signed [cle_pkg::VALUE_W-1:0]  value;

	modport source (output valid, action, value, input ready);
	modport sink (input valid, action, value, output ready);
endinterface

FILE: sv/cle_out_if.sv
`timescale 1ns / 1ps
interface cle_out_if;
	logic                         valid;
	logic                         ready;
	logic [cle_pkg::STATUS_W-1:0] status;
	logic [cle_pkg::POS_W-1:0]    position;
	logic [cle_pkg::COUNT_W-1:0]  entry_count;

	modport source (output valid, status, position, entry_count, input ready);
	modport sink (input valid, status, position, entry_count, output ready);
endinterface

FILE: sv/circular_list_engine_unit.sv
`timescale 1ns / 1ps
// Bounded ordered list of signed 32-bit words kept in a ring of CAPACITY slots.
// req channel: one word per request, action (insert tail, insert head, delete
//   first match, search) and value; taken when valid and ready are both high.
// rsp channel: exactly one word per request: status, position from the head
//   and the entry count after the request.
// Inserts need no scan. Search and delete read one entry a cycle from the
//   entry memory (registered read, one write port); search stops at the first
//   match, while delete goes on to the last entry, since the entries behind the
//   match are moved down one slot each.
// One request is worked at a time; ready is high only while the engine idles.
// The result sits in an output register, so the next request is taken while
//   a previous result still waits; if the receiver stalls longer, the engine
//   holds its finished result internally until the register frees.
// Reset empties the list and clears the head slot; no clearing pass is run.
module circular_list_engine_unit #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	cle_in_if.sink    req,
	cle_out_if.source rsp
);
	import cle_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    ready;

	cle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	cle_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_action      (req.action),
		.req_value       (req.value),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_status      (rsp.status),
		.rsp_position    (rsp.position),
		.rsp_entry_count (rsp.entry_count)
	);

	assign req.ready = ready;

endmodule

FILE: sv/cle_dp.sv
`timescale 1ns / 1ps
module cle_dp #(
	parameter int CAPACITY = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cle_pkg::dp_cmd_t                    cmd,
	output cle_pkg::dp_sts_t                    sts,
	input  logic [cle_pkg::ACTION_W-1:0]        req_action,
	input  logic signed [cle_pkg::VALUE_W-1:0]  req_value,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [cle_pkg::STATUS_W-1:0]        rsp_status,
	output logic [cle_pkg::POS_W-1:0]           rsp_position,
	output logic [cle_pkg::COUNT_W-1:0]         rsp_entry_count
);
	import cle_pkg::*;

	localparam int SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int SUMW = CW + 1;
	localparam logic [SW-1:0]   LAST_SLOT = SW'(CAPACITY - 1);
	localparam logic [SUMW-1:0] CAP_SUM   = SUMW'(CAPACITY);
	localparam logic [CW-1:0]   CAP_CNT   = CW'(CAPACITY);

	logic signed [VALUE_W-1:0] mem_q [CAPACITY];

	action_t                   action_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [SW-1:0]             head_q;
	logic [CW-1:0]             count_q;
	logic [SW-1:0]             rd_slot_q;
	logic [CW-1:0]             rd_idx_q;
	logic                      cmp_vld_q;
	logic [CW-1:0]             cmp_idx_q;
	logic [SW-1:0]             cmp_slot_q;
	logic [SW-1:0]             wr_slot_q;
	logic [CW-1:0]             pos_q;
	logic signed [VALUE_W-1:0] rdata_q;
	logic                      rsp_valid_q;
	status_t                   rsp_status_q;
	logic [POS_W-1:0]          rsp_pos_q;
	logic [COUNT_W-1:0]        rsp_cnt_q;

	logic [SUMW-1:0]           tail_sum;
	logic [SW-1:0]             tail_slot;
	logic [SW-1:0]             new_head;
	logic [SW-1:0]             next_rd_slot;
	logic                      wr_en;
	logic [SW-1:0]             wr_addr;
	logic signed [VALUE_W-1:0] wr_data;

	always_comb begin
		tail_sum     = SUMW'(head_q) + SUMW'(count_q);
		tail_slot    = (tail_sum >= CAP_SUM) ? SW'(tail_sum - CAP_SUM) : SW'(tail_sum);
		new_head     = (head_q == '0) ? LAST_SLOT : head_q - 1'b1;
		next_rd_slot = (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + 1'b1;
		wr_en        = cmd.ins || cmd.shift_wr;
		wr_addr      = wr_slot_q;
		wr_data      = rdata_q;
		if (cmd.ins) begin
			wr_addr = (action_q == ACT_INS_HEAD) ? new_head : tail_slot;
			wr_data = value_q;
		end
	end

	always_comb begin
		sts.action   = action_q;
		sts.full     = (count_q == CAP_CNT);
		sts.empty    = (count_q == '0);
		sts.match    = cmp_vld_q && (rdata_q == value_q);
		sts.last     = cmp_vld_q && (cmp_idx_q == count_q - 1'b1);
		sts.cmp_vld  = cmp_vld_q;
		sts.out_free = !rsp_valid_q || rsp_ready;
	end

	// entry store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.scan_step) begin
			rdata_q <= mem_q[rd_slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			cmp_vld_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + 1'b1;
				if (action_q == ACT_INS_HEAD) begin
					head_q <= new_head;
				end
			end
			if (cmd.del_commit) begin
				count_q <= count_q - 1'b1;
				if (count_q == CW'(1)) begin
					head_q <= '0;
				end
			end
			if (cmd.scan_init) begin
				rd_idx_q  <= '0;
				cmp_vld_q <= 1'b0;
			end else if (cmd.scan_step) begin
				cmp_vld_q <= (rd_idx_q != count_q);
				if (rd_idx_q != count_q) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action_t'(req_action);
			value_q  <= req_value;
		end
		if (cmd.ins) begin
			pos_q <= (action_q == ACT_INS_HEAD) ? '0 : count_q;
		end
		if (cmd.scan_init) begin
			rd_slot_q <= head_q;
		end else if (cmd.scan_step) begin
			rd_slot_q  <= next_rd_slot;
			cmp_idx_q  <= rd_idx_q;
			cmp_slot_q <= rd_slot_q;
		end
		// delete: write slot trails the read by one entry
		if (cmd.cap_pos) begin
			pos_q     <= cmp_idx_q;
			wr_slot_q <= cmp_slot_q;
		end else if (cmd.shift_wr) begin
			wr_slot_q <= cmp_slot_q;
		end
		if (cmd.finish) begin
			rsp_status_q <= cmd.status;
			rsp_pos_q    <= (cmd.status == ST_OK) ? POS_W'(pos_q) : '0;
			rsp_cnt_q    <= COUNT_W'(count_q);
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp_status      = rsp_status_q;
	assign rsp_position    = rsp_pos_q;
	assign rsp_entry_count = rsp_cnt_q;

endmodule

FILE: sv/cle_ctrl.sv
`timescale 1ns / 1ps
module cle_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output cle_pkg::dp_cmd_t cmd,
	input  cle_pkg::dp_sts_t sts
);
	import cle_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_FIN
	} state_t;

	state_t  state_q;
	status_t status_q;
	logic    is_insert;

	assign is_insert = (sts.action == ACT_INS_TAIL) || (sts.action == ACT_INS_HEAD);
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.status = status_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
			end
			S_EXEC: begin
				if (is_insert) begin
					cmd.ins = !sts.full;
				end else begin
					cmd.scan_init = !sts.empty;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.cap_pos   = sts.match;
			end
			S_SHIFT: begin
				cmd.scan_step  = 1'b1;
				cmd.shift_wr   = sts.cmp_vld;
				cmd.del_commit = !sts.cmp_vld;
			end
			S_FIN: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd.status = status_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (is_insert) begin
						status_q <= sts.full ? ST_FULL : ST_OK;
						state_q  <= S_FIN;
					end else if (sts.empty) begin
						status_q <= ST_EMPTY;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					priority if (sts.match) begin
						status_q <= ST_OK;
						state_q  <= (sts.action == ACT_DELETE) ? S_SHIFT : S_FIN;
					end else if (sts.last) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SHIFT: begin
					if (!sts.cmp_vld) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: test/tb_circular_list_engine_unit.sv
`timescale 1ns / 1ps
module tb_circular_list_engine_unit;
	import cle_pkg::*;

	localparam int CAPACITY = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;

	typedef struct {
		status_t              status;
		logic [POS_W-1:0]     position;
		logic [COUNT_W-1:0]   entry_count;
	} list_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cle_in_if  req_ch ();
	cle_out_if rsp_ch ();

	circular_list_engine_unit #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the ring
	logic [VALUE_W-1:0] list_ring [CAPACITY];
	int unsigned        ring_head;
	int unsigned        ring_len;

	list_answer_t answers_due [$];

	int errors;
	int sent_count;
	int checked_count;
	int cycle_count;
	int status_seen [4];
	int gap_pct;
	int stall_pct;
	bit calm;

	logic [VALUE_W-1:0] value_pool [8] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFE, 32'h5A5A_A5A5
	};

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycle_count,
				answers_due.size());
			$display("circular_list_engine_unit: mismatch");
			$finish;
		end
	end

	task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
		$display("%0t ns: %s: expected %0d, got %0d (result %0d)", $time, what, want, got,
			checked_count);
		errors++;
	endtask

	function automatic list_answer_t predict_request(action_t act, logic [VALUE_W-1:0] val);
		list_answer_t ans;
		int unsigned  idx;
		int unsigned  hit_at;
		bit           hit;
		ans.status   = ST_OK;
		ans.position = '0;
		hit = 1'b0;
		hit_at = 0;
		if (act == ACT_INS_TAIL || act == ACT_INS_HEAD) begin
			if (ring_len >= CAPACITY) begin
				ans.status = ST_FULL;
			end else if (act == ACT_INS_TAIL) begin
				list_ring[(ring_head + ring_len) % CAPACITY] = val;
				ans.position = POS_W'(ring_len);
				ring_len++;
			end else begin
				ring_head = (ring_head + CAPACITY - 1) % CAPACITY;
				list_ring[ring_head] = val;
				ring_len++;
			end
		end else if (ring_len == 0) begin
			ans.status = ST_EMPTY;
		end else begin
			for (idx = 0; idx < ring_len; idx++) begin
				if (!hit && list_ring[(ring_head + idx) % CAPACITY] == val) begin
					hit = 1'b1;
					hit_at = idx;
				end
			end
			if (!hit) begin
				ans.status = ST_NOT_FOUND;
			end else begin
				ans.position = POS_W'(hit_at);
				if (act == ACT_DELETE) begin
					// entries behind the match move down one slot
					for (idx = hit_at; idx + 1 < ring_len; idx++)
						list_ring[(ring_head + idx) % CAPACITY] =
							list_ring[(ring_head + idx + 1) % CAPACITY];
					ring_len--;
					if (ring_len == 0)
						ring_head = 0;
				end
			end
		end
		ans.entry_count = COUNT_W'(ring_len);
		return ans;
	endfunction

	task automatic send_word(action_t act, logic [VALUE_W-1:0] val);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.value  <= val;
		do @(posedge clk); while (!req_ch.ready);
		answers_due.push_back(predict_request(act, val));
		status_seen[answers_due[$].status]++;
		sent_count++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] live_value();
		return list_ring[(ring_head + $urandom_range(0, ring_len - 1)) % CAPACITY];
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (ring_len > 0 && r < 55)
			return live_value();
		if (r < 75)
			return value_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	function automatic action_t pick_action(int ins_pct);
		if ($urandom_range(0, 9) == 0)
			return action_t'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < ins_pct)
			return $urandom_range(0, 1) ? ACT_INS_HEAD : ACT_INS_TAIL;
		return $urandom_range(0, 1) ? ACT_DELETE : ACT_SEARCH;
	endfunction

	// receiver side: random back-pressure bursts
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : rsp_check
		list_answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (answers_due.size() == 0) begin
				report_mismatch("result word with no request pending", 0, 0);
			end else begin
				want = answers_due.pop_front();
				checked_count++;
				if (rsp_ch.status !== want.status)
					report_mismatch("status", want.status, rsp_ch.status);
				if (rsp_ch.position !== want.position)
					report_mismatch("position", want.position, rsp_ch.position);
				if (rsp_ch.entry_count !== want.entry_count)
					report_mismatch("entry_count", want.entry_count, rsp_ch.entry_count);
			end
		end
	end

	task automatic test_empty_list();
		send_word(ACT_SEARCH, 32'h0000_0000);
		send_word(ACT_DELETE, 32'h8000_0000);
	endtask

	task automatic test_insert_extremes();
		send_word(ACT_INS_TAIL, 32'h7FFF_FFFF);
		send_word(ACT_INS_TAIL, 32'h8000_0000);
		send_word(ACT_INS_HEAD, 32'h0000_0000);
		send_word(ACT_INS_HEAD, 32'hFFFF_FFFF);
		send_word(ACT_INS_TAIL, 32'h0000_0001);
	endtask

	task automatic test_search();
		send_word(ACT_SEARCH, 32'h8000_0000);
		send_word(ACT_SEARCH, 32'hFFFF_FFFF);
		send_word(ACT_SEARCH, 32'h0000_0001);
		send_word(ACT_SEARCH, 32'h1234_5678);
	endtask

	task automatic test_duplicates();
		// second zero at the tail; only the one nearer the head matches
		send_word(ACT_INS_TAIL, 32'h0000_0000);
		send_word(ACT_SEARCH, 32'h0000_0000);
		send_word(ACT_DELETE, 32'h0000_0000);
		send_word(ACT_SEARCH, 32'h0000_0000);
	endtask

	task automatic test_delete();
		send_word(ACT_DELETE, 32'h0000_0005);
		send_word(ACT_DELETE, 32'h8000_0000);
		send_word(ACT_DELETE, 32'hFFFF_FFFF);
		send_word(ACT_DELETE, 32'h0000_0000);
		send_word(ACT_DELETE, 32'h7FFF_FFFF);
		send_word(ACT_DELETE, 32'h0000_0001);
		send_word(ACT_DELETE, 32'h0000_0001);
		send_word(ACT_INS_HEAD, 32'h5555_5555);
		send_word(ACT_INS_TAIL, 32'hAAAA_AAAA);
		send_word(ACT_SEARCH, 32'hAAAA_AAAA);
	endtask

	task automatic test_fill_and_refuse();
		gap_pct = 10;
		stall_pct = 0;
		while (ring_len < CAPACITY)
			send_word($urandom_range(0, 1) ? ACT_INS_HEAD : ACT_INS_TAIL,
				$urandom_range(0, 3) == 0 ? pick_value() : $urandom());
		send_word(ACT_INS_TAIL, $urandom());
		send_word(ACT_INS_HEAD, $urandom());
		wait_drained();
		stall_pct = 30;
		// deepest scans: last entry, then delete at the head shifts everything
		send_word(ACT_SEARCH, list_ring[(ring_head + CAPACITY - 1) % CAPACITY]);
		send_word(ACT_SEARCH, $urandom());
		send_word(ACT_DELETE, list_ring[ring_head]);
		send_word(ACT_INS_TAIL, $urandom());
		send_word(ACT_INS_HEAD, $urandom());
		send_word(ACT_DELETE, list_ring[(ring_head + CAPACITY - 1) % CAPACITY]);
	endtask

	task automatic test_drain_list();
		gap_pct = 15;
		stall_pct = 15;
		while (ring_len > 0) begin
			if ($urandom_range(0, 4) == 0)
				send_word($urandom_range(0, 1) ? ACT_DELETE : ACT_SEARCH, $urandom());
			else
				send_word(ACT_DELETE, live_value());
		end
		send_word(ACT_SEARCH, $urandom());
		send_word(ACT_DELETE, $urandom());
	endtask

	task automatic test_random_mix(int n_words);
		int ins_pct;
		int k;
		ins_pct = 50;
		for (k = 0; k < n_words; k++) begin
			if (k % 50 == 0) begin
				// swing between growing and shrinking to visit full and empty
				case ($urandom_range(0, 4))
					0: ins_pct = 90;
					1: ins_pct = 10;
					2: ins_pct = 70;
					3: ins_pct = 30;
					default: ins_pct = 50;
				endcase
				gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
				stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			end
			if (k == n_words / 2)
				wait_drained();
			send_word(pick_action(ins_pct), pick_value());
		end
	endtask

	initial begin
		req_ch.valid  = 1'b0;
		req_ch.action = ACT_INS_TAIL;
		req_ch.value  = '0;
		ring_head = 0;
		ring_len = 0;
		calm = 1'b0;
		gap_pct = 20;
		stall_pct = 20;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_insert_extremes();
		test_search();
		test_duplicates();
		test_delete();
		wait_drained();
		test_fill_and_refuse();
		test_drain_list();
		test_random_mix(640);
		calm = 1'b1;
		test_random_mix(60);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d requests, %0d result words checked, list filled and emptied",
			sent_count, checked_count);
		$display("status mix: ok %0d, full %0d, not found %0d, empty %0d",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
			status_seen[ST_EMPTY]);
		if (errors == 0) begin
			$display("circular_list_engine_unit: match");
		end else begin
			$display("%0d mismatches", errors);
			$display("circular_list_engine_unit: mismatch");
		end
		$finish;
	end

endmodule
